@@ rtl/core/aecc_pkg.sv @@
`default_nettype none
package aecc_pkg;

  // signed q16.16 coordinate
  typedef logic signed [31:0] coord_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

  // origin z after reset, 30.0
  localparam coord_t ORIGIN_Z_RESET = 32'sd1966080;

  // saturate a 36-bit signed value to 32 bits
  function automatic coord_t sat32(input logic signed [35:0] v);
    coord_t r;
    if (v[35:31] != {5{v[35]}}) begin
      r = v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // select one of three axis values
  function automatic coord_t pick3(input logic [1:0] idx, input coord_t a,
                                   input coord_t b, input coord_t c);
    coord_t r;
    case (idx)
      2'd0: r = a;
      2'd1: r = b;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/aabb_eye_collision_clip.sv @@
// sequence: a load word or an ignored box goes straight to the result; any
//   other box is scaled axis by axis on the shared multiplier and the eye is
//   tested against it; while the eye is inside, each face is tried in turn: a
//   set-up step, the shared restoring divider, then the shared multiplier
// flow: one word at a time; the next word is accepted after the result is taken
// reset: synchronous; eye cleared, pass open, origin set to (0, 0, 30.0)
`default_nettype none
module aabb_eye_collision_clip (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   mode,
  input  aecc_pkg::coord_t      eye_in_x,
  input  aecc_pkg::coord_t      eye_in_y,
  input  aecc_pkg::coord_t      eye_in_z,
  input  aecc_pkg::coord_t      box_center_x,
  input  aecc_pkg::coord_t      box_center_y,
  input  aecc_pkg::coord_t      box_center_z,
  input  wire [30:0]            box_length,
  input  wire [30:0]            box_width,
  input  wire [30:0]            box_height,
  input  wire [30:0]            box_scale,
  output logic                  out_valid,
  input  wire                   out_ready,
  output aecc_pkg::coord_t      eye_out_x,
  output aecc_pkg::coord_t      eye_out_y,
  output aecc_pkg::coord_t      eye_out_z,
  output logic                  pushed,
  output logic                  pass_done,
  input  wire                   cfg_we,
  input  wire [1:0]             cfg_index,
  input  aecc_pkg::coord_t      cfg_data
);
  import aecc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXT  = 4'd1;
  localparam logic [3:0] S_EXTW = 4'd2;
  localparam logic [3:0] S_INS  = 4'd3;
  localparam logic [3:0] S_FACE = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_MULW = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state;
  logic [1:0] ax;
  logic       sub;
  logic       finished;
  coord_t     org_x, org_y, org_z;
  coord_t     eye_x, eye_y, eye_z;
  coord_t     hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
  coord_t     cen_x, cen_y, cen_z;
  logic [30:0] ext_x, ext_y, ext_z, scl;
  coord_t     fval, nw_a;
  logic [16:0] t;
  logic [48:0] div_r, div_ds;
  logic [4:0]  div_cnt;
  logic signed [65:0] prod;

  // per-axis views
  logic [1:0] k1, k2, ko;
  coord_t     e_ax, o_ax, h_ax, l_ax, c_ax, e_ko, o_ko, h_ko, l_ko;
  logic [30:0] x_ax;

  assign k1 = (ax == 2'd0) ? 2'd1 : 2'd0;
  assign k2 = (ax == 2'd2) ? 2'd1 : 2'd2;
  assign ko = sub ? k2 : k1;
  assign e_ax = pick3(ax, eye_x, eye_y, eye_z);
  assign o_ax = pick3(ax, org_x, org_y, org_z);
  assign h_ax = pick3(ax, hi_x, hi_y, hi_z);
  assign l_ax = pick3(ax, lo_x, lo_y, lo_z);
  assign c_ax = pick3(ax, cen_x, cen_y, cen_z);
  assign e_ko = pick3(ko, eye_x, eye_y, eye_z);
  assign o_ko = pick3(ko, org_x, org_y, org_z);
  assign h_ko = pick3(ko, hi_x, hi_y, hi_z);
  assign l_ko = pick3(ko, lo_x, lo_y, lo_z);
  always_comb begin
    case (ax)
      2'd0: x_ax = ext_x;
      2'd1: x_ax = ext_y;
      default: x_ax = ext_z;
    endcase
  end

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod_next;
  logic signed [32:0] diff_ko;
  assign diff_ko = {o_ko[31], o_ko} - {e_ko[31], e_ko};
  always_comb begin
    if (state == S_EXT) begin
      mul_a = {3'b000, x_ax};
      mul_b = {1'b0, scl};
    end else begin
      mul_a = {diff_ko[32], diff_ko};
      mul_b = {15'd0, t};
    end
  end
  assign prod_next = mul_a * mul_b;

  // scaled half extent and box bounds
  logic [30:0] ps31;
  logic [29:0] half;
  coord_t      hi_new, lo_new;
  assign ps31   = (|prod[61:47]) ? 31'h7fff_ffff : prod[46:16];
  assign half   = ps31[30:1];
  assign hi_new = sat32({{4{c_ax[31]}}, c_ax} + {6'd0, half});
  assign lo_new = sat32({{4{c_ax[31]}}, c_ax} - {6'd0, half});

  // eye strictly inside box
  logic eye_in_box;
  assign eye_in_box = (eye_x < hi_x) && (eye_x > lo_x) && (eye_y < hi_y) &&
                      (eye_y > lo_y) && (eye_z < hi_z) && (eye_z > lo_z);

  // face choice and divider set-up
  logic        use_hi, use_lo;
  coord_t      f_sel;
  logic signed [32:0] den, fe;
  logic [32:0] den_mag, fe_mag;
  assign use_hi  = o_ax > h_ax;
  assign use_lo  = o_ax < l_ax;
  assign f_sel   = use_hi ? h_ax : l_ax;
  assign den     = {o_ax[31], o_ax} - {e_ax[31], e_ax};
  assign fe      = {f_sel[31], f_sel} - {e_ax[31], e_ax};
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign fe_mag  = fe[32] ? 33'(-fe) : 33'(fe);

  // divider step
  logic        div_ge;
  assign div_ge = div_r >= div_ds;

  // crossing coordinate, product scaled back toward zero
  logic signed [50:0] p51, adj;
  logic signed [34:0] q35;
  coord_t             nw;
  logic               nw_ok;
  assign p51   = prod[50:0];
  assign adj   = p51 + (p51[50] ? 51'sd65535 : 51'sd0);
  assign q35   = adj[50:16];
  assign nw    = sat32({{4{e_ko[31]}}, e_ko} + {q35[34], q35});
  assign nw_ok = (nw < h_ko) && (nw > l_ko);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign eye_out_x = eye_x;
  assign eye_out_y = eye_y;
  assign eye_out_z = eye_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= ORIGIN_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: org_x <= cfg_data;
        CFG_ORIGIN_Y: org_y <= cfg_data;
        CFG_ORIGIN_Z: org_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finished  <= 1'b0;
      eye_x     <= '0;
      eye_y     <= '0;
      eye_z     <= '0;
      pushed    <= 1'b0;
      pass_done <= 1'b0;
      ax        <= '0;
      sub       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pushed    <= 1'b0;
            pass_done <= 1'b0;
            ax        <= '0;
            cen_x <= box_center_x;
            cen_y <= box_center_y;
            cen_z <= box_center_z;
            ext_x <= box_length;
            ext_y <= box_width;
            ext_z <= box_height;
            scl   <= box_scale;
            if (!mode) begin
              eye_x    <= eye_in_x;
              eye_y    <= eye_in_y;
              eye_z    <= eye_in_z;
              finished <= 1'b0;
              state    <= S_OUT;
            end else if (finished) begin
              pass_done <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_EXT;
            end
          end
        end
        S_EXT: begin
          prod  <= prod_next;
          state <= S_EXTW;
        end
        S_EXTW: begin
          case (ax)
            2'd0: begin hi_x <= hi_new; lo_x <= lo_new; end
            2'd1: begin hi_y <= hi_new; lo_y <= lo_new; end
            default: begin hi_z <= hi_new; lo_z <= lo_new; end
          endcase
          if (ax == 2'd2) begin
            state <= S_INS;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_EXT;
          end
        end
        S_INS: begin
          ax    <= '0;
          state <= eye_in_box ? S_FACE : S_OUT;
        end
        S_FACE: begin
          if ((use_hi || use_lo) && (den != '0)) begin
            fval    <= f_sel;
            div_r   <= {fe_mag, 16'd0};
            div_ds  <= {den_mag, 16'd0};
            div_cnt <= 5'd16;
            t       <= '0;
            state   <= S_DIV;
          end else if (ax == 2'd2) begin
            state <= S_OUT;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            div_r <= div_r - div_ds;
          end
          div_ds  <= div_ds >> 1;
          t       <= {t[15:0], div_ge};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            sub   <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          state <= S_MULW;
        end
        S_MULW: begin
          if (!nw_ok) begin
            if (ax == 2'd2) begin
              state <= S_OUT;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_FACE;
            end
          end else if (!sub) begin
            nw_a  <= nw;
            sub   <= 1'b1;
            state <= S_MUL;
          end else begin
            // commit the move onto the face
            case (ax)
              2'd0: begin eye_x <= fval; eye_y <= nw_a; eye_z <= nw; end
              2'd1: begin eye_y <= fval; eye_x <= nw_a; eye_z <= nw; end
              default: begin eye_z <= fval; eye_x <= nw_a; eye_y <= nw; end
            endcase
            pushed   <= 1'b1;
            finished <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/aecc_checker.sv @@
`default_nettype none
module aecc_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire pushed,
  input wire pass_done,
  input wire [31:0] eye_out_x
);

  // one word in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  // next cycle after an accept the input side is closed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accept");

  // a push and an ignored box never come together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pushed && pass_done))
    else $error("pushed and pass_done both set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(eye_out_x)))
    else $error("result changed under stall");

endmodule

bind aabb_eye_collision_clip aecc_checker u_aecc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pushed(pushed),
  .pass_done(pass_done), .eye_out_x(eye_out_x)
);
`default_nettype wire
